[hw/rtl/lbkv_pkg.sv]
// ----------------------------------------------------------------------------
// lbkv_pkg
// Shared constants, command codes and types of the bounded key/value table.
// ----------------------------------------------------------------------------
package lbkv_pkg;

    // Table geometry.
    localparam int DEPTH  = 16;
    localparam int KEY_W  = 32;
    localparam int ID_W   = 32;
    localparam int RANK_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Capacity after reset.
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    // Command codes.
    localparam logic [1:0] CMD_SET    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_LOOKUP = 2'd3;

    // Data handed from one cell to the next along the row.
    typedef struct packed {
        logic              hit;
        logic [RANK_W-1:0] rank;
        logic [ID_W-1:0]   id;
        logic              taken;
    } t_chain;

    // Command broadcast to every cell during the update cycle.
    typedef struct packed {
        logic              upd;
        logic [1:0]        cmd;
        logic [CNT_W-1:0]  evict;
        logic [CNT_W-1:0]  count;
        logic [KEY_W-1:0]  key;
        logic [ID_W-1:0]   id;
    } t_ctl;

    // Outcome of the key search, gathered at the end of the row.
    typedef struct packed {
        logic              hit;
        logic [RANK_W-1:0] rank;
    } t_hit;

endpackage

[hw/rtl/lru_bounded_key_value_table.sv]
// ----------------------------------------------------------------------------
// lru_bounded_key_value_table
// Bounded key/value table with oldest-write eviction, built as a row of cells.
// ----------------------------------------------------------------------------
// o_done and the results are registered from busy, which the start transfer
// sets; o_done is raised and the result fields are loaded together.
// No new command is taken while busy is high. busy is high for the cycle after
// a transfer, while the match flags travel down the row and the cells update.
// Reset (synchronous, active low) empties the table and sets capacity to 16.
// Results are shown for one cycle only; the receiver cannot stall them.
module lru_bounded_key_value_table
    import lbkv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_command,
    input  logic [KEY_W-1:0] i_key,
    input  logic [ID_W-1:0]  i_id_value,
    output logic             o_done,
    output logic             o_hit,
    output logic [ID_W-1:0]  o_id_out,
    output logic [CNT_W-1:0] o_evicted,
    output logic [CNT_W-1:0] o_occupancy
);

    logic             r_busy;
    logic [1:0]       r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [ID_W-1:0]  r_id;
    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] w_cap_eff;
    logic [CNT_W-1:0] w_evict;
    logic             w_accept;
    logic             w_set_miss;
    t_ctl             w_ctl;
    t_hit             w_hit;
    t_chain           w_chain [DEPTH+1];

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    // Number of oldest entries to drop if this command is an insert.
    always_comb begin
        w_cap_eff = (r_cap > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_cap;
        if (r_count >= w_cap_eff) begin
            w_evict = (w_cap_eff == '0) ? r_count : (r_count - w_cap_eff + 1'b1);
        end else begin
            w_evict = '0;
        end
    end

    // Broadcast of the command to the cells.
    always_comb begin
        w_ctl.upd   = r_busy;
        w_ctl.cmd   = r_cmd;
        w_ctl.evict = w_evict;
        w_ctl.count = r_count;
        w_ctl.key   = r_key;
        w_ctl.id    = r_id;
    end

    // The row of cells.
    assign w_chain[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        lbkv_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmp_en  (w_accept),
            .i_cmp_key (i_key),
            .i_ctl     (w_ctl),
            .i_hit     (w_hit),
            .i_chain   (w_chain[g]),
            .o_chain   (w_chain[g+1])
        );
    end

    // Search outcome taken from the end of the row.
    assign w_hit.hit  = w_chain[DEPTH].hit;
    assign w_hit.rank = w_chain[DEPTH].rank;

    assign w_set_miss = (r_cmd == CMD_SET) && !w_hit.hit;

    // Entry count after the command.
    always_comb begin
        case (r_cmd)
            CMD_SET:    n_count = w_hit.hit ? r_count : (r_count - w_evict + 1'b1);
            CMD_REMOVE: n_count = w_hit.hit ? (r_count - 1'b1) : r_count;
            CMD_CLEAR:  n_count = '0;
            default:    n_count = r_count;
        endcase
    end

    // Command capture and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            r_cap   <= CAP_RESET;
            o_done  <= 1'b0;
        end else begin
            o_done <= r_busy;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end
        end
    end

    // Captured command payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_command;
            r_key <= i_key;
            r_id  <= i_id_value;
        end
    end

    // Result register, loaded in the update cycle.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            o_hit       <= w_hit.hit && (r_cmd != CMD_CLEAR);
            o_id_out    <= (w_hit.hit && r_cmd == CMD_LOOKUP) ? w_chain[DEPTH].id : '0;
            o_evicted   <= w_set_miss ? w_evict : '0;
            o_occupancy <= n_count;
        end
    end

endmodule

[hw/rtl/lbkv_cell.sv]
// ----------------------------------------------------------------------------
// lbkv_cell
// One entry of the table: key, id, valid flag and write-order rank, with its
// own key compare and rank update, linked to its neighbours by a chain.
// ----------------------------------------------------------------------------
module lbkv_cell
    import lbkv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmp_en,
    input  logic [KEY_W-1:0] i_cmp_key,
    input  t_ctl             i_ctl,
    input  t_hit             i_hit,
    input  t_chain           i_chain,
    output t_chain           o_chain
);

    logic              r_valid, n_valid;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [ID_W-1:0]   r_id, n_id;
    logic              r_match;
    logic              w_free;
    logic              w_take;
    logic              w_old;

    // The cell is free for an insert if empty or about to be evicted.
    assign w_old  = ({1'b0, r_rank} < i_ctl.evict);
    assign w_free = !r_valid || w_old;
    assign w_take = w_free && !i_chain.taken;

    // Pass the search result and the free-slot claim down the row.
    always_comb begin
        o_chain.hit   = i_chain.hit | r_match;
        o_chain.rank  = i_chain.rank | (r_match ? r_rank : '0);
        o_chain.id    = i_chain.id | (r_match ? r_id : '0);
        o_chain.taken = i_chain.taken | w_free;
    end

    // Next state of the entry for the command in flight.
    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_key   = r_key;
        n_id    = r_id;
        if (i_ctl.upd) begin
            case (i_ctl.cmd)
                CMD_SET: begin
                    if (i_hit.hit) begin
                        if (r_match) begin
                            n_rank = RANK_W'(i_ctl.count - 1'b1);
                            n_id   = i_ctl.id;
                        end else if (r_valid && r_rank > i_hit.rank) begin
                            n_rank = r_rank - 1'b1;
                        end
                    end else if (w_take) begin
                        n_valid = 1'b1;
                        n_key   = i_ctl.key;
                        n_id    = i_ctl.id;
                        n_rank  = RANK_W'(i_ctl.count - i_ctl.evict);
                    end else if (r_valid && w_old) begin
                        n_valid = 1'b0;
                        n_rank  = '0;
                    end else if (r_valid) begin
                        n_rank = RANK_W'({1'b0, r_rank} - i_ctl.evict);
                    end
                end
                CMD_REMOVE: begin
                    if (i_hit.hit) begin
                        if (r_match) begin
                            n_valid = 1'b0;
                            n_rank  = '0;
                        end else if (r_valid && r_rank > i_hit.rank) begin
                            n_rank = r_rank - 1'b1;
                        end
                    end
                end
                CMD_CLEAR: begin
                    n_valid = 1'b0;
                    n_rank  = '0;
                end
                CMD_LOOKUP: begin
                    n_valid = r_valid;
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    // Control state of the entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
            if (i_cmp_en) begin
                r_match <= r_valid && (i_cmp_key == r_key);
            end
        end
    end

    // Payload of the entry.
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_id  <= n_id;
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded key/value table with oldest-write
// eviction. A short table of hand-picked commands opens the run, then some
// seventeen hundred random commands over several capacity settings. Every
// command is scored against a typed reply or the bench's behavioural table copy.
// ----------------------------------------------------------------------------
module tb;
    import lbkv_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 20;
    localparam int N_DIR       = 27;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 212;

    // One reply of the table.
    typedef struct packed {
        logic             hit;
        logic [ID_W-1:0]  id_out;
        logic [CNT_W-1:0] evicted;
        logic [CNT_W-1:0] occupancy;
    } t_outcome;

    typedef enum logic {ROW_CMD, ROW_CAP} t_row_kind;

    // One row of the directed stimulus: a command or a capacity write.
    typedef struct packed {
        t_row_kind        kind;
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  idv;
        logic [CNT_W-1:0] cap;
        logic             typed;
        t_outcome         want;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;
    logic             start;
    logic             busy;
    logic [1:0]       i_command;
    logic [KEY_W-1:0] i_key;
    logic [ID_W-1:0]  i_id_value;
    logic             o_done;
    logic             o_hit;
    logic [ID_W-1:0]  o_id_out;
    logic [CNT_W-1:0] o_evicted;
    logic [CNT_W-1:0] o_occupancy;

    // Bench copy of the table.
    logic [KEY_W-1:0] tbl_key   [DEPTH];
    logic [ID_W-1:0]  tbl_id    [DEPTH];
    bit               tbl_valid [DEPTH];
    int               tbl_rank  [DEPTH];
    int               tbl_count;
    logic [CNT_W-1:0] cap_reg;

    t_outcome         awaited_replies [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    bit               idle_on;
    int               n_fail;
    int               n_replies;
    int               n_hits;
    int               n_evicted;
    int               n_full;
    int               n_caps;
    int               n_cmd [4];
    int               cycle_cnt;

    // Hand-picked commands; typed replies where the answer is obvious.
    t_row dir_rows [N_DIR] = '{
        '{ROW_CMD, CMD_LOOKUP, 32'h0, 32'h0, 5'd0, 1'b1, '{1'b0, 32'h0, 5'd0, 5'd0}},
        '{ROW_CMD, CMD_SET, 32'h0, 32'h0, 5'd0, 1'b1, '{1'b0, 32'h0, 5'd0, 5'd1}},
        '{ROW_CMD, CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1,
          '{1'b0, 32'h0, 5'd0, 5'd2}},
        '{ROW_CMD, CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 5'd0, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 5'd0, 5'd2}},
        '{ROW_CMD, CMD_LOOKUP, 32'h0, 32'hFFFF_FFFF, 5'd0, 1'b1, '{1'b1, 32'h0, 5'd0, 5'd2}},
        '{ROW_CMD, CMD_REMOVE, 32'h5A5A_5A5A, 32'h0, 5'd0, 1'b1, '{1'b0, 32'h0, 5'd0, 5'd2}},
        '{ROW_CMD, CMD_SET, 32'h0, 32'hA5A5_A5A5, 5'd0, 1'b1, '{1'b1, 32'h0, 5'd0, 5'd2}},
        '{ROW_CMD, CMD_LOOKUP, 32'h0, 32'h0, 5'd0, 1'b0, '0},
        '{ROW_CMD, CMD_REMOVE, 32'hFFFF_FFFF, 32'h0, 5'd0, 1'b1, '{1'b1, 32'h0, 5'd0, 5'd1}},
        '{ROW_CMD, CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1,
          '{1'b0, 32'h0, 5'd0, 5'd0}},
        '{ROW_CMD, CMD_LOOKUP, 32'h0, 32'h0, 5'd0, 1'b1, '{1'b0, 32'h0, 5'd0, 5'd0}},
        '{ROW_CAP, CMD_SET, 32'h0, 32'h0, 5'd2, 1'b0, '0},
        '{ROW_CMD, CMD_SET, 32'h11, 32'h1, 5'd0, 1'b0, '0},
        '{ROW_CMD, CMD_SET, 32'h22, 32'h2, 5'd0, 1'b0, '0},
        '{ROW_CMD, CMD_SET, 32'h11, 32'h3, 5'd0, 1'b0, '0},
        '{ROW_CMD, CMD_SET, 32'h33, 32'h4, 5'd0, 1'b1, '{1'b0, 32'h0, 5'd1, 5'd2}},
        '{ROW_CMD, CMD_LOOKUP, 32'h22, 32'h0, 5'd0, 1'b1, '{1'b0, 32'h0, 5'd0, 5'd2}},
        '{ROW_CAP, CMD_SET, 32'h0, 32'h0, 5'd31, 1'b0, '0},
        '{ROW_CMD, CMD_SET, 32'h44, 32'h5, 5'd0, 1'b0, '0},
        '{ROW_CMD, CMD_SET, 32'h55, 32'h6, 5'd0, 1'b0, '0},
        '{ROW_CAP, CMD_SET, 32'h0, 32'h0, 5'd1, 1'b0, '0},
        '{ROW_CMD, CMD_SET, 32'h66, 32'h7, 5'd0, 1'b1, '{1'b0, 32'h0, 5'd4, 5'd1}},
        '{ROW_CAP, CMD_SET, 32'h0, 32'h0, 5'd0, 1'b0, '0},
        '{ROW_CMD, CMD_SET, 32'h66, 32'h8, 5'd0, 1'b1, '{1'b1, 32'h0, 5'd0, 5'd1}},
        '{ROW_CMD, CMD_SET, 32'h77, 32'h9, 5'd0, 1'b1, '{1'b0, 32'h0, 5'd1, 5'd1}},
        '{ROW_CMD, CMD_REMOVE, 32'h77, 32'h0, 5'd0, 1'b1, '{1'b1, 32'h0, 5'd0, 5'd0}},
        '{ROW_CMD, CMD_REMOVE, 32'h77, 32'h0, 5'd0, 1'b0, '0}
    };

    // Capacity used by each random phase; the extremes are among them.
    logic [CNT_W-1:0] phase_caps [N_PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31,
                                                5'd5, 5'd16, 5'd12, 5'd17};

    lru_bounded_key_value_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_key       (i_key),
        .i_id_value  (i_id_value),
        .o_done      (o_done),
        .o_hit       (o_hit),
        .o_id_out    (o_id_out),
        .o_evicted   (o_evicted),
        .o_occupancy (o_occupancy)
    );

    // Clock, 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Close the gap left in the write order by a rank that leaves it.
    function automatic void close_rank(input int gone);
        for (int i = 0; i < DEPTH; i++) begin
            if (tbl_valid[i] && tbl_rank[i] > gone) begin
                tbl_rank[i]--;
            end
        end
    endfunction

    function automatic void drop_cell(input int c);
        int gone;
        gone         = tbl_rank[c];
        tbl_valid[c] = 1'b0;
        tbl_rank[c]  = 0;
        close_rank(gone);
        if (tbl_count > 0) begin
            tbl_count--;
        end
    endfunction

    // Apply one command to the bench table and work out the reply.
    function automatic void apply_table_cmd(input logic [1:0] cmd,
                                            input logic [KEY_W-1:0] key,
                                            input logic [ID_W-1:0] idv,
                                            output t_outcome reply);
        int found;
        int lim;
        int oldest;
        int slot;
        found = -1;
        reply = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (found < 0 && tbl_valid[i] && tbl_key[i] == key) begin
                found = i;
            end
        end
        reply.hit = (found >= 0);
        case (cmd)
            CMD_SET: begin
                if (found >= 0) begin
                    close_rank(tbl_rank[found]);
                    tbl_rank[found] = tbl_count - 1;
                    tbl_id[found]   = idv;
                end else begin
                    lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
                    // Evict oldest entries until there is room under the capacity.
                    while (tbl_count > 0 && tbl_count >= lim) begin
                        oldest = -1;
                        for (int i = 0; i < DEPTH; i++) begin
                            if (oldest < 0 && tbl_valid[i] && tbl_rank[i] == 0) begin
                                oldest = i;
                            end
                        end
                        if (oldest < 0) begin
                            break;
                        end
                        drop_cell(oldest);
                        reply.evicted++;
                    end
                    // The lowest free cell takes the new entry as the newest.
                    slot = -1;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (slot < 0 && !tbl_valid[i]) begin
                            slot = i;
                        end
                    end
                    if (slot >= 0) begin
                        tbl_valid[slot] = 1'b1;
                        tbl_key[slot]   = key;
                        tbl_id[slot]    = idv;
                        tbl_rank[slot]  = tbl_count;
                        tbl_count++;
                    end
                end
            end
            CMD_REMOVE: begin
                if (found >= 0) begin
                    drop_cell(found);
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) begin
                    tbl_valid[i] = 1'b0;
                    tbl_rank[i]  = 0;
                end
                tbl_count = 0;
                reply.hit = 1'b0;
            end
            default: begin
                if (found >= 0) begin
                    reply.id_out = tbl_id[found];
                end
            end
        endcase
        reply.occupancy = CNT_W'(tbl_count);
    endfunction

    // Present one command, wait for its transfer and queue the expected reply.
    task automatic drive_cmd(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [ID_W-1:0] idv, input logic typed,
                             input t_outcome typed_reply);
        t_outcome predicted;
        if (idle_on && $urandom_range(99) < 12) begin
            start = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        start      = 1'b1;
        i_command  = cmd;
        i_key      = key;
        i_id_value = idv;
        do begin
            @(posedge i_clk);
        end while (busy);
        apply_table_cmd(cmd, key, idv, predicted);
        awaited_replies.push_back(typed ? typed_reply : predicted);
        n_cmd[cmd]++;
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every queued reply has come back.
    task automatic drain_replies();
        start = 1'b0;
        while (awaited_replies.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Capacity is only written while the table is idle.
    task automatic set_capacity(input logic [CNT_W-1:0] value);
        drain_replies();
        repeat (2) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        cap_reg     = value;
        n_caps++;
    endtask

    // Score each reply against the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (awaited_replies.size() == 0) begin
                $error("reply with no command outstanding");
                n_fail++;
            end else begin
                want = awaited_replies.pop_front();
                n_replies++;
                n_hits    += o_hit;
                n_evicted += o_evicted;
                if (o_occupancy == CNT_W'(DEPTH)) begin
                    n_full++;
                end
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    n_fail++;
                end
                if (o_id_out !== want.id_out) begin
                    $error("id_out: expected %h, got %h", want.id_out, o_id_out);
                    n_fail++;
                end
                if (o_evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, o_evicted);
                    n_fail++;
                end
                if (o_occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, o_occupancy);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus: reset, the directed table, then random phases.
    initial begin
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
        int               roll;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        start       = 1'b0;
        i_command   = CMD_SET;
        i_key       = '0;
        i_id_value  = '0;
        idle_on     = 1'b1;
        n_fail      = 0;
        n_replies   = 0;
        n_hits      = 0;
        n_evicted   = 0;
        n_full      = 0;
        n_caps      = 0;
        cycle_cnt   = 0;
        n_cmd       = '{0, 0, 0, 0};
        cap_reg     = CAP_RESET;
        tbl_count   = 0;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_key[i]   = '0;
            tbl_id[i]    = '0;
            tbl_valid[i] = 1'b0;
            tbl_rank[i]  = 0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part.
        for (int r = 0; r < N_DIR; r++) begin
            if (dir_rows[r].kind == ROW_CAP) begin
                set_capacity(dir_rows[r].cap);
            end else begin
                drive_cmd(dir_rows[r].cmd, dir_rows[r].key, dir_rows[r].idv,
                          dir_rows[r].typed, dir_rows[r].want);
            end
        end

        // Random part: mostly keys from a small pool so that hits and
        // evictions are frequent, with a sprinkling of arbitrary keys.
        for (int p = 0; p < N_PHASES; p++) begin
            set_capacity(phase_caps[p]);
            idle_on = (p != 5);
            for (int k = 0; k < POOL_SIZE; k++) begin
                key_pool[k] = $urandom;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(99);
                if (roll < 45) begin
                    cmd = CMD_SET;
                end else if (roll < 65) begin
                    cmd = CMD_REMOVE;
                end else if (roll < 67) begin
                    cmd = CMD_CLEAR;
                end else begin
                    cmd = CMD_LOOKUP;
                end
                key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                                : KEY_W'($urandom);
                drive_cmd(cmd, key, $urandom, 1'b0, '0);
                // Hold the sender off once, halfway through each phase, until the table is quiet.
                if (n == PHASE_ITEMS / 2) begin
                    drain_replies();
                    repeat ($urandom_range(1, 4)) @(negedge i_clk);
                end
            end
        end

        drain_replies();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d set, %0d remove, %0d clear, %0d lookup over %0d capacity writes.",
                 n_cmd[CMD_SET], n_cmd[CMD_REMOVE], n_cmd[CMD_CLEAR], n_cmd[CMD_LOOKUP],
                 n_caps);
        $display("Checked %0d replies: %0d hits, %0d entries evicted, %0d with a full table.",
                 n_replies, n_hits, n_evicted, n_full);
        if (n_fail == 0 && awaited_replies.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
